[hw/rtl/cfrt_pkg.sv]
// ----------------------------------------------------------------------------
// cfrt_pkg: shared types for the clock frame replacement table
// Command codes, classified operations, result status codes, back end states
// and the layout of one frame table row.
// ----------------------------------------------------------------------------
package cfrt_pkg;

	typedef enum logic [2:0] {
		CMD_ALLOC  = 3'd0,
		CMD_FREE   = 3'd1,
		CMD_ACCESS = 3'd2,
		CMD_EVICT  = 3'd3,
		CMD_LEVEL  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		K_ALLOC,
		K_FREE,
		K_ACCESS,
		K_EVICT,
		K_LEVEL,
		K_BAD
	} op_kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_NO_VICTIM = 3'd3,
		ST_BAD_ARG   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_SCAN,
		BK_FINISH
	} back_state_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [19:0] page;
		logic [7:0]  owner;
		logic [26:0] virt;
		logic [5:0]  slot;
		logic [2:0]  level;
	} op_t;

	typedef struct packed {
		logic        used;
		logic        refd;
		logic [7:0]  owner;
		logic [19:0] frame;
		logic [26:0] virt;
	} row_t;

endpackage

[hw/rtl/cfrt_front.sv]
// ----------------------------------------------------------------------------
// cfrt_front: command intake
// Checks the arguments of each incoming word, turns it into an operation and
// holds it in a two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
module cfrt_front #(
	parameter int FRAMES = 64,
	parameter int OWNERS = 256,
	parameter int LEVELS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       command,
	input  logic [19:0]      frame_page,
	input  logic [7:0]       owner,
	input  logic [26:0]      virt_page,
	input  logic [5:0]       slot,
	input  logic [2:0]       level,
	output logic             q_valid,
	output cfrt_pkg::op_t    q_op,
	input  logic             pop
);
	import cfrt_pkg::*;

	op_t        op_new;
	op_t        q_mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       owner_ok;

	assign owner_ok = (owner != 8'd0) && (32'(owner) < OWNERS);

	always_comb begin
		op_new.page  = frame_page;
		op_new.owner = owner;
		op_new.virt  = virt_page;
		op_new.slot  = slot;
		op_new.level = level;
		case (command)
			CMD_ALLOC:  op_new.kind = (frame_page != 20'd0 && owner_ok) ? K_ALLOC : K_BAD;
			CMD_FREE:   op_new.kind = K_FREE;
			CMD_ACCESS: op_new.kind = (32'(slot) < FRAMES) ? K_ACCESS : K_BAD;
			CMD_EVICT:  op_new.kind = K_EVICT;
			CMD_LEVEL:  op_new.kind = (owner_ok && 32'(level) < LEVELS) ? K_LEVEL : K_BAD;
			default:    op_new.kind = K_BAD;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_op     = q_mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wp_q] <= op_new;
	end

endmodule

[hw/rtl/cfrt_back.sv]
// ----------------------------------------------------------------------------
// cfrt_back: table engine
// Holds the frame table and owner levels in memories, sweeps the table one
// row per cycle for all but level and bad operations and registers the result.
// ----------------------------------------------------------------------------
module cfrt_back #(
	parameter int FRAMES = 64,
	parameter int OWNERS = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  cfrt_pkg::op_t    q_op,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       status,
	output logic [5:0]       slot_out,
	output logic [19:0]      victim_page,
	output logic [7:0]       victim_owner,
	output logic [26:0]      victim_virt
);
	import cfrt_pkg::*;

	localparam int FW    = $clog2(FRAMES);
	localparam int OW    = $clog2(OWNERS);
	localparam int CW    = $clog2(2 * FRAMES + 1);
	localparam int CLR_N = (FRAMES > OWNERS) ? FRAMES : OWNERS;
	localparam int CLW   = $clog2(CLR_N);

	row_t        ent_mem [FRAMES];
	logic [2:0]  lvl_mem [OWNERS];

	back_state_t st_q, st_d;
	op_t         op_q;
	logic [CLW-1:0] clr_q;
	logic [FW-1:0]  addr_q;
	logic [CW-1:0]  cnt_q;
	logic           p1_v_q, p2_v_q;
	logic [FW-1:0]  p1_idx_q, p2_idx_q;
	row_t           ent_rd_q, p2_row_q;
	logic [2:0]     lvl_rd_q;
	logic           found_q, fb_q;
	logic [FW-1:0]  best_q, fb_idx_q, hand_q;
	logic [2:0]     best_lvl_q;
	row_t           best_row_q, fb_row_q;
	logic           out_valid_q;
	status_t        status_q;
	logic [5:0]     slot_q;
	row_t           vrow_q;

	logic           fin, scan_done;
	logic           ent_we, lvl_we;
	logic [FW-1:0]  ent_wa;
	row_t           ent_wd;
	logic [OW-1:0]  lvl_wa;
	logic [2:0]     lvl_wd;
	logic [FW-1:0]  vic_idx;
	row_t           vic_row;
	logic           vic_any;
	status_t        res_status;
	logic [5:0]     res_slot;
	row_t           res_row;

	assign pop       = (st_q == BK_IDLE) && q_valid;
	assign fin       = (st_q == BK_FINISH) && (!out_valid_q || !out_stall);
	assign scan_done = (cnt_q == '0) && !p1_v_q && !p2_v_q;
	assign vic_any   = found_q || fb_q;
	assign vic_idx   = found_q ? best_q : fb_idx_q;
	assign vic_row   = found_q ? best_row_q : fb_row_q;

	always_comb begin
		st_d       = st_q;
		ent_we     = 1'b0;
		ent_wa     = p1_idx_q;
		ent_wd     = '0;
		lvl_we     = 1'b0;
		lvl_wa     = OW'(op_q.owner);
		lvl_wd     = op_q.level;
		res_status = ST_BAD_ARG;
		res_slot   = 6'd0;
		res_row    = '0;
		case (st_q)
			BK_CLEAR: begin
				ent_we = (32'(clr_q) < FRAMES);
				ent_wa = FW'(clr_q);
				lvl_we = (32'(clr_q) < OWNERS);
				lvl_wa = OW'(clr_q);
				lvl_wd = 3'd0;
				if (32'(clr_q) == CLR_N - 1) st_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (pop) begin
					st_d = (q_op.kind == K_LEVEL || q_op.kind == K_BAD) ? BK_FINISH : BK_SCAN;
				end
			end
			BK_SCAN: begin
				// Second chance: a referenced owned entry loses its bit as the hand passes.
				ent_we = p1_v_q && (op_q.kind == K_EVICT) && ent_rd_q.used &&
					(ent_rd_q.owner != 8'd0) && ent_rd_q.refd;
				ent_wd = ent_rd_q;
				ent_wd.refd = 1'b0;
				if (scan_done) st_d = BK_FINISH;
			end
			BK_FINISH: begin
				ent_wa = best_q;
				case (op_q.kind)
					K_ALLOC: begin
						res_status = found_q ? ST_OK : ST_FULL;
						res_slot   = found_q ? 6'(best_q) : 6'd0;
						ent_we     = fin && found_q;
						ent_wd     = '{used: 1'b1, refd: 1'b0, owner: op_q.owner,
							frame: op_q.page, virt: op_q.virt};
					end
					K_FREE: begin
						res_status = found_q ? ST_OK : ST_NOT_FOUND;
						res_slot   = found_q ? 6'(best_q) : 6'd0;
						ent_we     = fin && found_q;
					end
					K_ACCESS: begin
						res_status = found_q ? ST_OK : ST_NOT_FOUND;
						res_slot   = found_q ? 6'(best_q) : 6'd0;
						ent_we     = fin && found_q;
						ent_wd     = best_row_q;
						ent_wd.refd = 1'b1;
					end
					K_EVICT: begin
						res_status = vic_any ? ST_OK : ST_NO_VICTIM;
						res_slot   = vic_any ? 6'(vic_idx) : 6'd0;
						res_row    = vic_any ? vic_row : '0;
						ent_we     = fin && vic_any;
						ent_wa     = vic_idx;
					end
					K_LEVEL: begin
						res_status = ST_OK;
						lvl_we     = fin;
					end
					default: res_status = ST_BAD_ARG;
				endcase
				if (fin) st_d = BK_IDLE;
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			addr_q      <= '0;
			p1_v_q      <= 1'b0;
			p2_v_q      <= 1'b0;
			found_q     <= 1'b0;
			fb_q        <= 1'b0;
			hand_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			p1_v_q <= (st_q == BK_SCAN) && (cnt_q != '0);
			p2_v_q <= p1_v_q;
			if (st_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
			if (pop) begin
				found_q <= 1'b0;
				fb_q    <= 1'b0;
				case (q_op.kind)
					K_ALLOC, K_FREE: begin
						cnt_q  <= CW'(FRAMES);
						addr_q <= '0;
					end
					K_ACCESS: begin
						cnt_q  <= CW'(1);
						addr_q <= FW'(q_op.slot);
					end
					K_EVICT: begin
						cnt_q  <= CW'(2 * FRAMES);
						addr_q <= hand_q;
					end
					default: cnt_q <= '0;
				endcase
			end else if (st_q == BK_SCAN && cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				addr_q <= (32'(addr_q) == FRAMES - 1) ? '0 : addr_q + 1'b1;
			end
			if (p2_v_q) begin
				case (op_q.kind)
					K_ALLOC: if (!found_q && !p2_row_q.used) found_q <= 1'b1;
					K_FREE: begin
						if (!found_q && p2_row_q.used && p2_row_q.frame == op_q.page)
							found_q <= 1'b1;
					end
					K_ACCESS: found_q <= p2_row_q.used;
					K_EVICT: begin
						if (p2_row_q.used && p2_row_q.owner != 8'd0) begin
							if (!p2_row_q.refd && (!found_q || best_lvl_q < lvl_rd_q))
								found_q <= 1'b1;
							if (!fb_q || p2_idx_q < fb_idx_q) fb_q <= 1'b1;
						end
					end
					default: found_q <= found_q;
				endcase
			end
			if (fin && op_q.kind == K_EVICT && vic_any)
				hand_q <= (32'(vic_idx) == FRAMES - 1) ? '0 : vic_idx + 1'b1;
			if (fin) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Candidate data follows the flag conditions; an access always stores its row.
	always_ff @(posedge clk) begin
		if (pop) op_q <= q_op;
		p1_idx_q <= addr_q;
		p2_idx_q <= p1_idx_q;
		p2_row_q <= ent_rd_q;
		if (p2_v_q) begin
			case (op_q.kind)
				K_ALLOC: if (!found_q && !p2_row_q.used) best_q <= p2_idx_q;
				K_FREE: begin
					if (!found_q && p2_row_q.used && p2_row_q.frame == op_q.page)
						best_q <= p2_idx_q;
				end
				K_ACCESS: begin
					best_q     <= p2_idx_q;
					best_row_q <= p2_row_q;
				end
				K_EVICT: begin
					if (p2_row_q.used && p2_row_q.owner != 8'd0) begin
						if (!p2_row_q.refd && (!found_q || best_lvl_q < lvl_rd_q)) begin
							best_q     <= p2_idx_q;
							best_lvl_q <= lvl_rd_q;
							best_row_q <= p2_row_q;
						end
						if (!fb_q || p2_idx_q < fb_idx_q) begin
							fb_idx_q <= p2_idx_q;
							fb_row_q <= p2_row_q;
						end
					end
				end
				default: best_q <= best_q;
			endcase
		end
		if (fin) begin
			status_q <= res_status;
			slot_q   <= res_slot;
			vrow_q   <= res_row;
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_wa] <= ent_wd;
		ent_rd_q <= ent_mem[addr_q];
		if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
		lvl_rd_q <= lvl_mem[OW'(ent_rd_q.owner)];
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slot_out     = slot_q;
	assign victim_page  = vrow_q.frame;
	assign victim_owner = vrow_q.owner;
	assign victim_virt  = vrow_q.virt;

`ifndef SYNTHESIS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (st_q == BK_SCAN || st_q == BK_FINISH))
		else $error("operation taken outside idle");
	a_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		p2_v_q |-> $past(p1_v_q))
		else $error("row pipeline out of step");
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (slot_q == 6'd0))
		else $error("failed result carries a slot");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_CLEAR) |-> (!out_valid_q && !pop))
		else $error("activity during clearing pass");
`endif

endmodule

[hw/rtl/clock_frame_replacement_table_unit.sv]
// Sweep: set level and bad commands read no row; access reads its one row;
// alloc and free sweep FRAMES rows; evict sweeps 2 * FRAMES rows.
// Throughput: one word at a time; the table sweep, one row read per cycle from the
// frame memory, sets the figure.
// Reset: asynchronous, active low; afterwards a clearing pass of max(FRAMES, OWNERS)
// rows (256 by default) zeroes both memories, and words only queue up meanwhile.
// ----------------------------------------------------------------------------
// clock_frame_replacement_table_unit: priority-weighted clock frame table
// A front end checks and queues commands; a back end runs them against the
// frame table and returns one result word per command.
// ----------------------------------------------------------------------------
module clock_frame_replacement_table_unit #(
	parameter int FRAMES = 64,
	parameter int OWNERS = 256,
	parameter int LEVELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [19:0] frame_page,
	input  logic [7:0]  owner,
	input  logic [26:0] virt_page,
	input  logic [5:0]  slot,
	input  logic [2:0]  level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [5:0]  slot_out,
	output logic [19:0] victim_page,
	output logic [7:0]  victim_owner,
	output logic [26:0] victim_virt
);
	import cfrt_pkg::*;

	// The queue between the two halves lets the front take up to two words while
	// the back end is busy sweeping the table or waiting on a stalled result.
	logic q_valid;
	op_t  q_op;
	logic pop;

	// Front end: argument checks and command classification.
	cfrt_front #(
		.FRAMES(FRAMES),
		.OWNERS(OWNERS),
		.LEVELS(LEVELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.frame_page (frame_page),
		.owner      (owner),
		.virt_page  (virt_page),
		.slot       (slot),
		.level      (level),
		.q_valid    (q_valid),
		.q_op       (q_op),
		.pop        (pop)
	);

	// Back end: table memories, the clock hand and the result register.
	cfrt_back #(
		.FRAMES(FRAMES),
		.OWNERS(OWNERS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_op         (q_op),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.slot_out     (slot_out),
		.victim_page  (victim_page),
		.victim_owner (victim_owner),
		.victim_virt  (victim_virt)
	);

endmodule

[tb/cfrt_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfrt_checker: result checker for the clock frame replacement table
// Watches both channels, keeps its own copy of the frame table and the owner
// levels, predicts one result per accepted command and compares in order.
// ----------------------------------------------------------------------------
module cfrt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  command,
	input  logic [19:0] frame_page,
	input  logic [7:0]  owner,
	input  logic [26:0] virt_page,
	input  logic [5:0]  slot,
	input  logic [2:0]  level,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [5:0]  slot_out,
	input  logic [19:0] victim_page,
	input  logic [7:0]  victim_owner,
	input  logic [26:0] victim_virt,
	output int          fail_count,
	output int          pending
);
	import cfrt_pkg::*;

	localparam int FRAMES = 64;

	typedef struct packed {
		logic [2:0]  st;
		logic [5:0]  slot;
		logic [19:0] page;
		logic [7:0]  owner;
		logic [26:0] virt;
	} outcome_t;

	row_t       table_rows [FRAMES];
	logic [2:0] levels [256];
	logic [5:0] sweep_pos;
	outcome_t   awaited [$];

	function automatic outcome_t run_command(logic [2:0] c, logic [19:0] pg, logic [7:0] ow,
			logic [26:0] vp, logic [5:0] sl, logic [2:0] lv);
		outcome_t r;
		bit found;
		int best;
		logic [2:0] best_lvl;
		int h;
		r = '0;
		r.st = ST_BAD_ARG;
		found = 0;
		best = 0;
		best_lvl = 0;
		case (c)
			CMD_ALLOC: begin
				if (pg != 0 && ow != 0) begin
					r.st = ST_FULL;
					for (int i = 0; i < FRAMES; i++)
						if (!table_rows[i].used) begin
							table_rows[i] = '{used: 1'b1, refd: 1'b0, owner: ow,
								frame: pg, virt: vp};
							r.st = ST_OK;
							r.slot = 6'(i);
							break;
						end
				end
			end
			CMD_FREE: begin
				r.st = ST_NOT_FOUND;
				for (int i = 0; i < FRAMES; i++)
					if (table_rows[i].used && table_rows[i].frame == pg) begin
						table_rows[i] = '0;
						r.st = ST_OK;
						r.slot = 6'(i);
						break;
					end
			end
			CMD_ACCESS: begin
				if (table_rows[sl].used) begin
					table_rows[sl].refd = 1'b1;
					r.st = ST_OK;
					r.slot = sl;
				end else begin
					r.st = ST_NOT_FOUND;
				end
			end
			CMD_EVICT: begin
				for (int k = 0; k < 2 * FRAMES; k++) begin
					h = sweep_pos;
					if (table_rows[h].used && table_rows[h].owner != 0) begin
						if (table_rows[h].refd) begin
							table_rows[h].refd = 1'b0;
						end else if (!found || best_lvl < levels[table_rows[h].owner]) begin
							found = 1;
							best = h;
							best_lvl = levels[table_rows[h].owner];
						end
					end
					sweep_pos = sweep_pos + 6'd1;
				end
				if (!found)
					for (int i = 0; i < FRAMES; i++)
						if (table_rows[i].used && table_rows[i].owner != 0) begin
							found = 1;
							best = i;
							break;
						end
				if (found) begin
					r.page = table_rows[best].frame;
					r.owner = table_rows[best].owner;
					r.virt = table_rows[best].virt;
					table_rows[best] = '0;
					sweep_pos = 6'(best + 1);
					r.st = ST_OK;
					r.slot = 6'(best);
				end else begin
					r.st = ST_NO_VICTIM;
				end
			end
			CMD_LEVEL: begin
				if (ow != 0) begin
					levels[ow] = lv;
					r.st = ST_OK;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		outcome_t seen;
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++)
				table_rows[i] = '0;
			for (int i = 0; i < 256; i++)
				levels[i] = '0;
			sweep_pos = '0;
			awaited.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (in_valid && !in_stall)
				awaited.push_back(run_command(command, frame_page, owner, virt_page,
					slot, level));
			if (out_valid && !out_stall) begin
				seen = '{st: status, slot: slot_out, page: victim_page,
					owner: victim_owner, virt: victim_virt};
				if (awaited.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word %h", seen);
				end else begin
					want = awaited.pop_front();
					if (want != seen) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: st %0d/%0d slot %0d/%0d page %h/%h owner %h/%h virt %h/%h",
								want.st, seen.st, want.slot, seen.slot, want.page, seen.page,
								want.owner, seen.owner, want.virt, seen.virt);
					end
				end
			end
			pending = awaited.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the clock frame replacement table
// Drives a directed set of commands and then random traffic shaped to fill,
// sweep and drain the table, with random idling on both channels. The checker
// beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
	import cfrt_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  command;
	logic [19:0] frame_page;
	logic [7:0]  owner;
	logic [26:0] virt_page;
	logic [5:0]  slot;
	logic [2:0]  level;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [5:0]  slot_out;
	logic [19:0] victim_page;
	logic [7:0]  victim_owner;
	logic [26:0] victim_virt;
	int          fail_count;
	int          pending;
	int          cycle_count;
	bit          calm;

	// A small pool of frame pages, so that frees usually hit something live.
	logic [19:0] recent_pages [16];

	clock_frame_replacement_table_unit u_dut (.*);

	cfrt_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: the slowest honest run is about 1800 words, each with its table
	// work plus random idling on both channels, well inside the limit below.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 1_500_000) begin
			$display("status: fail");
			$finish;
		end
	end

	// The receiver stalls in random bursts, and not at all once the run is calm.
	initial begin
		int burst;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, 19);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	// Offers one word and holds it until the block takes it. Valid is only dropped
	// when a gap follows, so it never falls and rises again in one step.
	task automatic send_word(logic [2:0] c, logic [19:0] pg, logic [7:0] ow,
			logic [26:0] vp, logic [5:0] sl, logic [2:0] lv);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= c;
		frame_page <= pg;
		owner      <= ow;
		virt_page  <= vp;
		slot       <= sl;
		level      <= lv;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Random word mix: mostly well-formed allocs, accesses and evicts so that the
	// table fills and the clock sweep sees referenced and unreferenced rows.
	task automatic random_word();
		int pick;
		logic [19:0] pg;
		pick = $urandom_range(0, 99);
		pg = (pick % 2) ? 20'($urandom_range(1, 40)) : 20'($urandom());
		if (pick < 35) begin
			if ($urandom_range(0, 19) == 0)
				pg = 0;
			recent_pages[$urandom_range(0, 15)] = pg;
			send_word(CMD_ALLOC, pg, ($urandom_range(0, 29) == 0) ? 8'd0 : 8'($urandom()),
				27'($urandom()), 6'($urandom()), 3'($urandom()));
		end else if (pick < 47) begin
			send_word(CMD_FREE, ($urandom_range(0, 3) == 0) ? 20'($urandom()) :
				recent_pages[$urandom_range(0, 15)], 8'($urandom()), 27'($urandom()),
				6'($urandom()), 3'($urandom()));
		end else if (pick < 72) begin
			send_word(CMD_ACCESS, 20'($urandom()), 8'($urandom()), 27'($urandom()),
				6'($urandom()), 3'($urandom()));
		end else if (pick < 87) begin
			send_word(CMD_EVICT, 20'($urandom()), 8'($urandom()), 27'($urandom()),
				6'($urandom()), 3'($urandom()));
		end else if (pick < 97) begin
			send_word(CMD_LEVEL, 20'($urandom()), ($urandom_range(0, 19) == 0) ? 8'd0 :
				8'($urandom()), 27'($urandom()), 6'($urandom()), 3'($urandom()));
		end else begin
			send_word(3'($urandom_range(5, 7)), 20'($urandom()), 8'($urandom()),
				27'($urandom()), 6'($urandom()), 3'($urandom()));
		end
	endtask

	initial begin
		int limit;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		command     = CMD_ALLOC;
		frame_page  = '0;
		owner       = '0;
		virt_page   = '0;
		slot        = '0;
		level       = '0;
		cycle_count = 0;
		calm        = 1'b0;
		for (int i = 0; i < 16; i++)
			recent_pages[i] = 20'(i + 1);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: an evict on an empty table, the bad argument cases, field
		// extremes, an access to an unused row and commands beyond the known range.
		send_word(CMD_EVICT, '0, '0, '0, '0, '0);
		send_word(CMD_ALLOC, '0, 8'd5, '1, '0, '0);
		send_word(CMD_ALLOC, 20'd7, 8'd0, '1, '0, '0);
		send_word(CMD_ALLOC, '1, '1, '1, '1, '1);
		send_word(CMD_ALLOC, 20'd1, 8'd1, '0, '0, '0);
		send_word(CMD_ALLOC, 20'd2, 8'd2, 27'h5555555, '0, '0);
		send_word(CMD_LEVEL, '0, '1, '0, '0, 3'd7);
		send_word(CMD_LEVEL, '0, 8'd2, '0, '0, 3'd5);
		send_word(CMD_LEVEL, '0, 8'd0, '0, '0, 3'd3);
		send_word(CMD_ACCESS, '0, '0, '0, 6'd0, '0);
		send_word(CMD_ACCESS, '0, '0, '0, '1, '0);
		send_word(CMD_EVICT, '0, '0, '0, '0, '0);
		send_word(CMD_FREE, '0, '0, '0, '0, '0);
		send_word(CMD_FREE, '1, '0, '0, '0, '0);
		send_word(CMD_FREE, 20'd12345, '0, '0, '0, '0);
		send_word(3'd5, '1, '1, '1, '1, '1);
		send_word(3'd7, '0, '0, '0, '0, '0);
		// Fill the table completely, overflow it, then mark every row referenced so
		// the sweep must clear every reference bit before it can choose a victim.
		for (int i = 0; i < 64; i++)
			send_word(CMD_ALLOC, 20'(i + 100), 8'(i % 4 + 1), 27'($urandom()), '0, '0);
		send_word(CMD_ALLOC, 20'd999, 8'd3, '0, '0, '0);
		for (int i = 0; i < 64; i++)
			send_word(CMD_ACCESS, '0, '0, '0, 6'(i), '0);
		send_word(CMD_EVICT, '0, '0, '0, '0, '0);

		// Random part; the last stretch runs with no idling at all.
		for (int n = 0; n < 1650; n++) begin
			if (n == 1450)
				calm = 1'b1;
			random_word();
		end
		in_valid <= 1'b0;

		limit = 0;
		while (pending != 0 && limit < 20000) begin
			@(posedge clk);
			limit++;
		end
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
